/* rtl/iec_pkg.sv */
`default_nettype none
package iec_pkg;

	localparam int ADDR_BITS = 16;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic        cmd;
		logic [15:0] load_address;
		logic [15:0] load_data;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_value;
		logic [15:0] pc_after;
	} out_word_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_NEWLINE = 2'd1;
	localparam logic [1:0] ST_DECOUT = 2'd2;
	localparam logic [1:0] ST_HALT = 2'd3;

	localparam logic [3:0] OP_BR = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd1;
	localparam logic [3:0] OP_LD = 4'd2;
	localparam logic [3:0] OP_ST = 4'd3;
	localparam logic [3:0] OP_BL = 4'd4;
	localparam logic [3:0] OP_AND = 4'd5;
	localparam logic [3:0] OP_LDR = 4'd6;
	localparam logic [3:0] OP_STR = 4'd7;
	localparam logic [3:0] OP_CMP = 4'd8;
	localparam logic [3:0] OP_NOT = 4'd9;
	localparam logic [3:0] OP_JMP = 4'd12;
	localparam logic [3:0] OP_MVI = 4'd13;
	localparam logic [3:0] OP_LEA = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [7:0] TV_HALT = 8'd0;
	localparam logic [7:0] TV_NL = 8'd1;
	localparam logic [7:0] TV_DEC = 8'd2;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_FETCH,
		EX_EXEC,
		EX_DATA
	} ex_state_t;

	function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
		logic [15:0] m;
		logic [15:0] s;
		m = 16'((32'd1 << bits) - 1);
		s = 16'(32'd1 << (bits - 1));
		return ((v & m) ^ s) - s;
	endfunction

endpackage
`default_nettype wire

/* rtl/iec_ram.sv */
`default_nettype none
module iec_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

/* rtl/iec_front.sv */
`default_nettype none
module iec_front
	import iec_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_word_t in_data,
	output logic          q_valid,
	input  wire logic     q_ready,
	output in_word_t      q_data
);

	localparam int PW = $clog2(QDEPTH);

	in_word_t         buf_q [QDEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	logic             push, pop;

	// small queue of words between front and back
	assign in_ready = (cnt_q != (PW+1)'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_data   = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

/* rtl/iec_back.sv */
`default_nettype none
module iec_back
	import iec_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_valid,
	output logic          q_ready,
	input  wire in_word_t q_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_word_t     out_data
);

	ex_state_t        state_q, state_d;
	logic [15:0]      rf_q [8];
	logic [15:0]      pc_q;
	logic [3:0]       nzcv_q;
	logic             halt_q;
	logic [15:0]      ir_q;
	out_word_t        res_q;
	logic             res_v_q;

	logic                 m_we;
	logic [ADDR_BITS-1:0] m_addr;
	logic [15:0]          m_wdata, m_rdata;

	iec_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
	);

	// decode of the fetched word
	logic [15:0] ir;
	logic [3:0]  op;
	logic [2:0]  dr, sr1, sr2;
	logic [15:0] pc1, off9, off11, off6, imm5, a, b, rdr, ea_pc, ea_r;
	logic        n, z, c, v, take;
	logic [16:0] sum;
	logic [15:0] addy;
	logic [15:0] r7n;

	assign ir    = m_rdata;
	assign op    = ir[15:12];
	assign dr    = ir[11:9];
	assign sr1   = ir[8:6];
	assign sr2   = ir[2:0];
	assign pc1   = pc_q + 16'd1;
	assign off9  = sext(ir, 9);
	assign off11 = sext(ir, 11);
	assign off6  = sext(ir, 6);
	assign imm5  = sext(ir, 5);
	assign a     = rf_q[sr1];
	assign b     = ir[5] ? imm5 : rf_q[sr2];
	assign rdr   = rf_q[dr];
	assign ea_pc = pc1 + off9;
	assign ea_r  = a + off6;
	assign {n, z, c, v} = nzcv_q;
	assign addy  = (op == OP_CMP) ? (16'd0 - b) : b;
	assign sum   = {1'b0, a} + {1'b0, addy};
	assign r7n   = (sr1 == 3'd7) ? pc1 : a;

	always_comb begin
		case (dr)
			3'd0: take = z;
			3'd1: take = !z;
			3'd2: take = n;
			3'd3: take = (n == z);
			3'd4: take = (n != v);
			3'd5: take = (n == v) && !z;
			3'd6: take = c;
			default: take = 1'b1;
		endcase
	end

	// next pc, status and printed value of the executed word
	logic [15:0] pc_nx;
	logic [1:0]  st_nx;
	logic [15:0] val_nx;

	always_comb begin
		pc_nx  = pc1;
		st_nx  = ST_NONE;
		val_nx = '0;
		case (op)
			OP_BR: if (take) begin
				pc_nx = ea_pc;
			end
			OP_BL: pc_nx = ir[11] ? (pc1 + off11) : (r7n + off6);
			OP_JMP: pc_nx = ea_r;
			OP_TRAP: begin
				if (ir[7:0] == TV_HALT) begin
					st_nx = ST_HALT;
				end else if (ir[7:0] == TV_NL) begin
					st_nx = ST_NEWLINE;
				end else if (ir[7:0] == TV_DEC) begin
					st_nx  = ST_DECOUT;
					val_nx = rdr;
				end
			end
			default: ;
		endcase
	end

	// result slot is free when empty or being taken
	logic slot_free;
	assign slot_free = !res_v_q || out_ready;
	assign out_valid = res_v_q;
	assign out_data  = res_q;

	// control: next state, memory port, queue pop
	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		m_we    = 1'b0;
		m_addr  = pc_q[ADDR_BITS-1:0];
		m_wdata = q_data.load_data;
		case (state_q)
			EX_IDLE: begin
				if (q_valid && slot_free) begin
					if (q_data.cmd == CMD_LOAD) begin
						q_ready = 1'b1;
						m_we    = 1'b1;
						m_addr  = q_data.load_address[ADDR_BITS-1:0];
					end else if (halt_q) begin
						q_ready = 1'b1;
					end else begin
						state_d = EX_EXEC;
					end
				end
			end
			EX_EXEC: begin
				q_ready = 1'b1;
				state_d = EX_IDLE;
				case (op)
					OP_LD: begin
						m_addr  = ea_pc[ADDR_BITS-1:0];
						q_ready = 1'b0;
						state_d = EX_DATA;
					end
					OP_LDR: begin
						m_addr  = ea_r[ADDR_BITS-1:0];
						q_ready = 1'b0;
						state_d = EX_DATA;
					end
					OP_ST: begin
						m_we    = 1'b1;
						m_addr  = ea_pc[ADDR_BITS-1:0];
						m_wdata = rdr;
					end
					OP_STR: begin
						m_we    = 1'b1;
						m_addr  = ea_r[ADDR_BITS-1:0];
						m_wdata = rdr;
					end
					default: ;
				endcase
			end
			EX_DATA: begin
				q_ready = 1'b1;
				state_d = EX_IDLE;
			end
			default: state_d = EX_IDLE;
		endcase
	end

	// result word loaded this cycle
	logic        res_load;
	logic [1:0]  res_st;
	logic [15:0] res_val, res_pc;

	always_comb begin
		res_load = 1'b0;
		res_st   = ST_NONE;
		res_val  = '0;
		res_pc   = pc_q;
		case (state_q)
			EX_IDLE: if (q_ready) begin
				res_load = 1'b1;
				res_st   = halt_q ? ST_HALT : ST_NONE;
			end
			EX_EXEC: if (q_ready) begin
				res_load = 1'b1;
				res_st   = st_nx;
				res_val  = val_nx;
				res_pc   = pc_nx;
			end
			EX_DATA: res_load = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) rf_q[i] <= '0;
			pc_q    <= '0;
			nzcv_q  <= '0;
			halt_q  <= 1'b0;
			res_v_q <= 1'b0;
			res_q   <= '0;
			ir_q    <= '0;
		end else begin
			if (res_load) begin
				res_v_q         <= 1'b1;
				res_q.status    <= res_st;
				res_q.out_value <= res_val;
				res_q.pc_after  <= res_pc;
			end else if (out_valid && out_ready) begin
				res_v_q <= 1'b0;
			end
			if (state_q == EX_DATA) begin
				rf_q[ir_q[11:9]] <= m_rdata;
			end
			if (state_q == EX_EXEC) begin
				ir_q <= ir;
				pc_q <= pc_nx;
				case (op)
					OP_ADD, OP_CMP: begin
						if (op == OP_ADD) rf_q[dr] <= sum[15:0];
						nzcv_q <= {sum[15], sum[15:0] == '0, sum[16],
							~(a[15] ^ addy[15]) & (a[15] ^ sum[15])};
					end
					OP_AND: begin
						rf_q[dr] <= a & b;
						nzcv_q[3:2] <= {a[15] & b[15], (a & b) == '0};
					end
					OP_NOT: begin
						rf_q[dr] <= ~a;
						nzcv_q[3:2] <= {~a[15], ~a == '0};
					end
					OP_BL: rf_q[7] <= pc1;
					OP_MVI: rf_q[dr] <= off9;
					OP_LEA: rf_q[dr] <= ea_pc;
					OP_TRAP: begin
						if (ir[7:0] == TV_HALT) halt_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/lcc_instruction_execute_core_top.sv */
// Load word: written to memory, result registered as it is taken from the queue.
// Step: fetch, execute, data read for ld/ldr. One load per cycle while the result slot is
// free; a step ends before the next word starts, set by the single-port program memory.
// A two-entry input queue decouples intake from execution.
// Reset clears registers, pc, flags and halt; program memory is undefined until written.
`default_nettype none
module lcc_instruction_execute_core_top
	import iec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	logic     q_valid, q_ready;
	in_word_t q_data;

	iec_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	iec_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
`default_nettype wire
